[rtl/ssfla_pkg.sv]
// shared constants and types for the slot store free-list allocator
// no dependencies; imported by the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package ssfla_pkg;

  localparam int MAX_SLOTS   = 4096;
  localparam int MAX_ENTRIES = 8;
  localparam int ENTRY_BITS  = 64;

  localparam int SLOT_W  = $clog2(MAX_SLOTS);
  localparam int POS_W   = $clog2(MAX_ENTRIES);
  localparam int COUNT_W = SLOT_W + 1;
  localparam int ADDR_W  = SLOT_W + POS_W;
  localparam int DEPTH   = MAX_SLOTS * MAX_ENTRIES;

  localparam int EPS_W   = 4;
  localparam int FILE_W  = 8;
  localparam int LIMIT_W = 13;
  localparam int INDEX_W = 16;
  localparam int LINK_W  = 32;
  localparam int CFG_W   = 13;

  localparam logic [1:0] CFG_EPS   = 2'd0;
  localparam logic [1:0] CFG_FILE  = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_GET    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ADDR = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

endpackage

`default_nettype wire

[rtl/slot_store_free_list_allocator_unit.sv]
// slot store with free-list allocation: sequencer, config registers, output register
// depends on ssfla_pkg and ssfla_ram
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+-----------------------------------------
// cfg      | in        | cfg_we_i                  | cfg_index_i, cfg_wdata_i
// in       | in        | in_valid_i / in_stall_o   | action, addr_file/index, entry_first/second
// out      | out       | out_valid_o / out_stall_i | status, out_file/index, entry_value/position,
//          |           |                           | last_entry
//
// one item at a time; the store's single write port and registered read set the pace.
// write: decode, link fetch when popping a free slot, one write per entry, response. get: decode,
// one entry per cycle unless the output stalls. delete: decode, one write per entry, response.
// failing items: decode, response. reset clears the used count and free-list head, resets config;
// the store itself is not cleared. a stalled output holds its item and the sequencer waits on it.

module slot_store_free_list_allocator_unit
  import ssfla_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [1:0]            action_i,
  input  wire logic [FILE_W-1:0]     addr_file_i,
  input  wire logic [INDEX_W-1:0]    addr_index_i,
  input  wire logic [ENTRY_BITS-1:0] entry_first_i,
  input  wire logic [ENTRY_BITS-1:0] entry_second_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [1:0]            status_o,
  output      logic [FILE_W-1:0]     out_file_o,
  output      logic [SLOT_W-1:0]     out_index_o,
  output      logic [ENTRY_BITS-1:0] entry_value_o,
  output      logic [POS_W-1:0]      entry_position_o,
  output      logic                  last_entry_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECODE   = 6'b000010,
    S_POP_LINK = 6'b000100,
    S_WRITE    = 6'b001000,
    S_GET      = 6'b010000,
    S_RESP     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [EPS_W-1:0]   eps_q;
  logic [FILE_W-1:0]  file_q;
  logic [LIMIT_W-1:0] limit_q;

  // allocator state
  logic [COUNT_W-1:0] used_q, used_d;
  logic [SLOT_W-1:0]  head_q, head_d;

  // item under work
  action_e             op_q;
  logic [FILE_W-1:0]   af_q;
  logic [INDEX_W-1:0]  ai_q;
  logic [ENTRY_BITS-1:0] first_q, second_q;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  status_e             status_q, status_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            o_status_q, o_status_d;
  logic [FILE_W-1:0]     o_file_q, o_file_d;
  logic [SLOT_W-1:0]     o_index_q, o_index_d;
  logic [ENTRY_BITS-1:0] o_value_q, o_value_d;
  logic [POS_W-1:0]      o_pos_q, o_pos_d;
  logic                  o_last_q, o_last_d;

  // memory port signals
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;

  logic [EPS_W-1:0]   eps_eff;
  logic [POS_W-1:0]   last_pos;
  logic [LIMIT_W-1:0] limit_eff;
  logic               in_accept, out_can, pos_last;
  logic [COUNT_W:0]   used_inc;
  logic [LINK_W-1:0]  link;

  localparam logic [EPS_W-1:0]   EPS_MIN   = EPS_W'(3);
  localparam logic [EPS_W-1:0]   EPS_MAX   = EPS_W'(MAX_ENTRIES);
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(MAX_SLOTS);

  assign eps_eff   = (eps_q < EPS_MIN) ? EPS_MIN : ((eps_q > EPS_MAX) ? EPS_MAX : eps_q);
  assign last_pos  = POS_W'(eps_eff - EPS_W'(1));
  assign limit_eff = (limit_q < LIMIT_MAX) ? limit_q : LIMIT_MAX;
  assign pos_last  = (pos_q == last_pos);
  assign used_inc  = {1'b0, used_q} + (COUNT_W + 1)'(1);
  assign link      = ram_rdata[LINK_W-1:0];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_can    = !out_valid_q || !out_stall_i;

  ssfla_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q   <= EPS_MIN;
      file_q  <= '0;
      limit_q <= LIMIT_W'(4096);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_EPS:   eps_q   <= cfg_wdata_i[EPS_W-1:0];
        CFG_FILE:  file_q  <= cfg_wdata_i[FILE_W-1:0];
        CFG_LIMIT: limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    head_d      = head_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    o_status_d  = o_status_q;
    o_file_d    = o_file_q;
    o_index_d   = o_index_q;
    o_value_d   = o_value_q;
    o_pos_d     = o_pos_q;
    o_last_d    = o_last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = {idx_q, pos_q};
    ram_raddr   = {idx_q, pos_q};
    ram_wdata   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_accept && action_e'(action_i) != ACT_NOP) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        pos_d    = '0;
        status_d = ST_OK;
        if (op_q == ACT_WRITE) begin
          if (head_q != '0 && COUNT_W'(head_q) <= used_q) begin
            // pop: fetch the link from entry 0 of the head slot
            idx_d     = head_q;
            ram_re    = 1'b1;
            ram_raddr = {head_q, POS_W'(0)};
            state_d   = S_POP_LINK;
          end else if (used_inc >= (COUNT_W + 1)'(limit_eff)) begin
            status_d = ST_FULL;
            state_d  = S_RESP;
          end else begin
            used_d  = used_inc[COUNT_W-1:0];
            idx_d   = used_inc[SLOT_W-1:0];
            state_d = S_WRITE;
          end
        end else begin
          if (ai_q == '0 || af_q != file_q || ai_q >= INDEX_W'(limit_eff)) begin
            status_d = ST_BAD_ADDR;
            state_d  = S_RESP;
          end else if (used_q == '0 || ai_q > INDEX_W'(used_q)) begin
            status_d = ST_NOT_ALLOC;
            state_d  = S_RESP;
          end else begin
            idx_d = ai_q[SLOT_W-1:0];
            if (op_q == ACT_GET) begin
              ram_re    = 1'b1;
              ram_raddr = {ai_q[SLOT_W-1:0], POS_W'(0)};
              state_d   = S_GET;
            end else begin
              state_d = S_WRITE;
            end
          end
        end
      end

      S_POP_LINK: begin
        // a link beyond the used range empties the list
        head_d  = (link > LINK_W'(used_q)) ? '0 : link[SLOT_W-1:0];
        state_d = S_WRITE;
      end

      S_WRITE: begin
        ram_we = 1'b1;
        if (pos_q == POS_W'(0)) begin
          ram_wdata = (op_q == ACT_DELETE) ? ENTRY_BITS'(head_q) : first_q;
        end else if (pos_q == POS_W'(1) && op_q == ACT_WRITE) begin
          ram_wdata = second_q;
        end
        if (pos_last) begin
          if (op_q == ACT_DELETE) begin
            head_d = idx_q;
          end
          state_d = S_RESP;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end

      S_GET: begin
        if (out_can) begin
          out_valid_d = 1'b1;
          o_status_d  = ST_OK;
          o_file_d    = '0;
          o_index_d   = '0;
          o_value_d   = ram_rdata;
          o_pos_d     = pos_q;
          o_last_d    = pos_last;
          if (pos_last) begin
            state_d = S_IDLE;
          end else begin
            // next entry read overlaps the hand-over of this one
            pos_d     = pos_q + POS_W'(1);
            ram_re    = 1'b1;
            ram_raddr = {idx_q, pos_q + POS_W'(1)};
          end
        end
      end

      S_RESP: begin
        if (out_can) begin
          out_valid_d = 1'b1;
          o_status_d  = status_q;
          o_value_d   = '0;
          o_pos_d     = '0;
          o_last_d    = 1'b1;
          if (op_q == ACT_WRITE && status_q == ST_OK) begin
            o_file_d  = file_q;
            o_index_d = idx_q;
          end else begin
            o_file_d  = '0;
            o_index_d = '0;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= action_e'(action_i);
      af_q     <= addr_file_i;
      ai_q     <= addr_index_i;
      first_q  <= entry_first_i;
      second_q <= entry_second_i;
    end
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    status_q   <= status_d;
    o_status_q <= o_status_d;
    o_file_q   <= o_file_d;
    o_index_q  <= o_index_d;
    o_value_q  <= o_value_d;
    o_pos_q    <= o_pos_d;
    o_last_q   <= o_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = o_status_q;
  assign out_file_o       = o_file_q;
  assign out_index_o      = o_index_q;
  assign entry_value_o    = o_value_q;
  assign entry_position_o = o_pos_q;
  assign last_entry_o     = o_last_q;

endmodule

`default_nettype wire

[rtl/ssfla_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ssfla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sim/tb.sv]
// testbench for slot_store_free_list_allocator_unit: directed table, then random phases
// checks every output item against an in-bench predictor of the slot store and free list
// depends on ssfla_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb;
  import ssfla_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 16;
  localparam int PHASE_ITEMS = 51;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    action_e               act;
    logic [FILE_W-1:0]     afile;
    logic [INDEX_W-1:0]    aidx;
    logic [ENTRY_BITS-1:0] first;
    logic [ENTRY_BITS-1:0] second;
  } item_t;

  typedef struct {
    status_e               status;
    logic [FILE_W-1:0]     file;
    logic [SLOT_W-1:0]     index;
    logic [ENTRY_BITS-1:0] value;
    logic [POS_W-1:0]      pos;
    logic                  last;
  } result_t;

  typedef struct {
    row_kind_e         kind;
    logic [1:0]        sel;
    logic [CFG_W-1:0]  val;
    item_t             it;
    bit                typed;
    int                n_typed;
    result_t           want;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [1:0]            cfg_index_i = '0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            action_i = '0;
  logic [FILE_W-1:0]     addr_file_i = '0;
  logic [INDEX_W-1:0]    addr_index_i = '0;
  logic [ENTRY_BITS-1:0] entry_first_i = '0;
  logic [ENTRY_BITS-1:0] entry_second_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            status_o;
  logic [FILE_W-1:0]     out_file_o;
  logic [SLOT_W-1:0]     out_index_o;
  logic [ENTRY_BITS-1:0] entry_value_o;
  logic [POS_W-1:0]      entry_position_o;
  logic                  last_entry_o;

  slot_store_free_list_allocator_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .addr_file_i      (addr_file_i),
    .addr_index_i     (addr_index_i),
    .entry_first_i    (entry_first_i),
    .entry_second_i   (entry_second_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .out_file_o       (out_file_o),
    .out_index_o      (out_index_o),
    .entry_value_o    (entry_value_o),
    .entry_position_o (entry_position_o),
    .last_entry_o     (last_entry_o)
  );

  // predictor state: configuration, allocator and a shadow of the store
  logic [EPS_W-1:0]       cfg_eps = 4'd3;
  logic [FILE_W-1:0]      cfg_file = '0;
  logic [LIMIT_W-1:0]     cfg_limit = 13'd4096;
  int                     used_cnt = 0;
  int                     free_top = 0;
  logic [ENTRY_BITS-1:0]  slot_mem [MAX_SLOTS][MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] slot_written [MAX_SLOTS];

  result_t slot_results_q[$];
  row_t    dir_rows[$];
  int      bad_cnt = 0;
  int      cycles = 0;
  bit      quiet_tx = 1'b0;
  bit      quiet_rx = 1'b0;
  int      stall_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("slot_store_free_list_allocator_unit regression: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet_rx && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic int eps_used();
    if (cfg_eps < 4'd3) return 3;
    if (int'(cfg_eps) > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(cfg_eps);
  endfunction

  function automatic int limit_used();
    if (int'(cfg_limit) < MAX_SLOTS) return int'(cfg_limit);
    return MAX_SLOTS;
  endfunction

  function automatic logic [MAX_ENTRIES-1:0] eps_mask(int e);
    logic [MAX_ENTRIES-1:0] m;
    int p;
    m = '0;
    for (p = 0; p < e; p++) m[p] = 1'b1;
    return m;
  endfunction

  function automatic status_e addr_check(logic [FILE_W-1:0] f, logic [INDEX_W-1:0] ix);
    if (ix == '0 || f != cfg_file || int'(ix) >= limit_used()) return ST_BAD_ADDR;
    if (used_cnt == 0 || int'(ix) > used_cnt) return ST_NOT_ALLOC;
    return ST_OK;
  endfunction

  // applies one accepted item to the shadow store, queues its results, returns their number
  function automatic int slot_store_predict(item_t it);
    int          e;
    int          ix;
    int          p;
    logic [31:0] link;
    status_e     st;
    result_t     r;
    e = eps_used();
    ix = int'(it.aidx);
    r = '{ST_OK, '0, '0, '0, '0, 1'b1};
    case (it.act)
      ACT_WRITE: begin
        if (free_top != 0 && free_top <= used_cnt) begin
          ix = free_top;
          link = slot_mem[ix][0][31:0];
          // a link past the used count means the list is corrupt: drop it
          free_top = (link > 32'(used_cnt)) ? 0 : int'(link);
        end else if (used_cnt + 1 >= limit_used()) begin
          r.status = ST_FULL;
          slot_results_q.push_back(r);
          return 1;
        end else begin
          used_cnt++;
          ix = used_cnt;
        end
        slot_mem[ix][0] = it.first;
        slot_mem[ix][1] = it.second;
        for (p = 2; p < e; p++) slot_mem[ix][p] = '0;
        slot_written[ix] |= eps_mask(e);
        r.file = cfg_file;
        r.index = SLOT_W'(ix);
        slot_results_q.push_back(r);
        return 1;
      end
      ACT_GET: begin
        st = addr_check(it.afile, it.aidx);
        if (st != ST_OK) begin
          r.status = st;
          slot_results_q.push_back(r);
          return 1;
        end
        for (p = 0; p < e; p++) begin
          r.value = slot_mem[ix][p];
          r.pos = POS_W'(p);
          r.last = (p == e - 1);
          slot_results_q.push_back(r);
        end
        return e;
      end
      ACT_DELETE: begin
        st = addr_check(it.afile, it.aidx);
        if (st != ST_OK) begin
          r.status = st;
          slot_results_q.push_back(r);
          return 1;
        end
        for (p = 0; p < e; p++) slot_mem[ix][p] = '0;
        slot_mem[ix][0] = ENTRY_BITS'(free_top);
        free_top = ix;
        slot_written[ix] |= eps_mask(e);
        slot_results_q.push_back(r);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    r;
    int    hi;
    r = $urandom_range(0, 99);
    it.first = {$urandom, $urandom};
    it.second = {$urandom, $urandom};
    it.afile = FILE_W'($urandom);
    it.aidx = INDEX_W'($urandom);
    if (r < 40) begin
      it.act = ACT_WRITE;
    end else if (r < 88) begin
      it.act = (r < 72) ? ACT_GET : ACT_DELETE;
      it.afile = cfg_file;
      hi = (used_cnt < limit_used() - 1) ? used_cnt : limit_used() - 1;
      if (hi >= 1 && r % 5 != 0) it.aidx = INDEX_W'($urandom_range(1, hi));
      else it.aidx = INDEX_W'($urandom_range(0, used_cnt + 2));
    end else begin
      it.act = action_e'($urandom_range(0, 3));
    end
    // never read entries that no write has reached yet
    if (it.act == ACT_GET && addr_check(it.afile, it.aidx) == ST_OK &&
        (slot_written[it.aidx[SLOT_W-1:0]] & eps_mask(eps_used())) != eps_mask(eps_used()))
      it.aidx = '0;
    return it;
  endfunction

  function automatic row_t op_row(action_e act, logic [FILE_W-1:0] f,
                                  logic [INDEX_W-1:0] ix, logic [ENTRY_BITS-1:0] d0,
                                  logic [ENTRY_BITS-1:0] d1);
    row_t r;
    r.kind = ROW_ITEM;
    r.it = '{act, f, ix, d0, d1};
    r.typed = 1'b0;
    r.n_typed = 0;
    return r;
  endfunction

  function automatic row_t chk_row(action_e act, logic [FILE_W-1:0] f,
                                   logic [INDEX_W-1:0] ix, logic [ENTRY_BITS-1:0] d0,
                                   logic [ENTRY_BITS-1:0] d1, int n, status_e st,
                                   logic [FILE_W-1:0] of, logic [SLOT_W-1:0] oi);
    row_t r;
    r = op_row(act, f, ix, d0, d1);
    r.typed = 1'b1;
    r.n_typed = n;
    r.want = '{st, of, oi, '0, '0, 1'b1};
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] sel, logic [CFG_W-1:0] val);
    row_t r;
    r.kind = ROW_CFG;
    r.sel = sel;
    r.val = val;
    r.typed = 1'b0;
    r.n_typed = 0;
    return r;
  endfunction

  // lowers valid in the step it is called, then waits for every result and the tail
  task automatic drain();
    in_valid_i <= 1'b0;
    while (slot_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] sel, logic [CFG_W-1:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      CFG_EPS:  cfg_eps = val[EPS_W-1:0];
      CFG_FILE: cfg_file = val[FILE_W-1:0];
      default:  cfg_limit = val[LIMIT_W-1:0];
    endcase
    @(posedge clk_i);
  endtask

  // returns in the step of acceptance, with valid still high
  task automatic send_item(input item_t it, output int n);
    int gap;
    gap = quiet_tx ? 0 : gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= it.act;
    addr_file_i <= it.afile;
    addr_index_i <= it.aidx;
    entry_first_i <= it.first;
    entry_second_i <= it.second;
    do @(posedge clk_i); while (in_stall_o);
    n = slot_store_predict(it);
  endtask

  always @(posedge clk_i) begin : check_out
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (slot_results_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected item: status %0d file %0d index %0d value %h pos %0d last %0b",
                   status_o, out_file_o, out_index_o, entry_value_o, entry_position_o,
                   last_entry_o);
      end else begin
        want = slot_results_q.pop_front();
        if (status_o !== want.status || out_file_o !== want.file ||
            out_index_o !== want.index || entry_value_o !== want.value ||
            entry_position_o !== want.pos || last_entry_o !== want.last) begin
          bad_cnt++;
          if (bad_cnt <= 10) begin
            $display("mismatch: expected status %0d file %0d index %0d value %h pos %0d last %0b",
                     want.status, want.file, want.index, want.value, want.pos, want.last);
            $display("          got      status %0d file %0d index %0d value %h pos %0d last %0b",
                     status_o, out_file_o, out_index_o, entry_value_o, entry_position_o,
                     last_entry_o);
          end
        end
      end
    end
  end

  initial begin
    item_t it;
    int    n;
    int    phase;
    int    done;
    int    k;
    foreach (slot_written[s]) slot_written[s] = '0;

    // reset state: three entries per slot, file 0, full limit
    dir_rows.push_back(chk_row(ACT_GET, 8'h00, 16'd1, '0, '0, 1, ST_NOT_ALLOC, 8'h00, 12'd0));
    dir_rows.push_back(chk_row(ACT_DELETE, 8'h00, 16'd0, '0, '0, 1, ST_BAD_ADDR, 8'h00, 12'd0));
    dir_rows.push_back(chk_row(ACT_NOP, 8'hFF, 16'hFFFF, '1, '1, 0, ST_OK, 8'h00, 12'd0));
    dir_rows.push_back(cfg_row(CFG_LIMIT, 13'd3));
    dir_rows.push_back(chk_row(ACT_WRITE, 8'h00, 16'd0, '1, '0, 1, ST_OK, 8'h00, 12'd1));
    dir_rows.push_back(chk_row(ACT_WRITE, 8'hFF, 16'hFFFF, '0, '1, 1, ST_OK, 8'h00, 12'd2));
    dir_rows.push_back(chk_row(ACT_WRITE, 8'h00, 16'd0, '1, '1, 1, ST_FULL, 8'h00, 12'd0));
    dir_rows.push_back(chk_row(ACT_GET, 8'h00, 16'd3, '0, '0, 1, ST_BAD_ADDR, 8'h00, 12'd0));
    dir_rows.push_back(chk_row(ACT_GET, 8'hFF, 16'd1, '0, '0, 1, ST_BAD_ADDR, 8'h00, 12'd0));
    dir_rows.push_back(op_row(ACT_GET, 8'h00, 16'd1, '0, '0));
    dir_rows.push_back(op_row(ACT_DELETE, 8'h00, 16'd2, '0, '0));
    // second delete of the same slot links it to itself
    dir_rows.push_back(op_row(ACT_DELETE, 8'h00, 16'd2, '0, '0));
    dir_rows.push_back(chk_row(ACT_WRITE, 8'h00, 16'd0, '1, 64'h0, 1, ST_OK, 8'h00, 12'd2));
    // the popped link is now all ones: list emptied
    dir_rows.push_back(chk_row(ACT_WRITE, 8'h00, 16'd0, 64'h0123_4567_89AB_CDEF,
                               64'hFEDC_BA98_7654_3210, 1, ST_OK, 8'h00, 12'd2));
    dir_rows.push_back(chk_row(ACT_WRITE, 8'h00, 16'd0, '0, '0, 1, ST_FULL, 8'h00, 12'd0));
    dir_rows.push_back(op_row(ACT_GET, 8'h00, 16'd2, '0, '0));
    dir_rows.push_back(cfg_row(CFG_EPS, 13'd15));
    dir_rows.push_back(cfg_row(CFG_FILE, 13'd255));
    dir_rows.push_back(cfg_row(CFG_LIMIT, 13'd8191));
    dir_rows.push_back(chk_row(ACT_WRITE, 8'h00, 16'd0, 64'h8000_0000_0000_0001,
                               64'h7FFF_FFFF_FFFF_FFFE, 1, ST_OK, 8'hFF, 12'd3));
    dir_rows.push_back(op_row(ACT_GET, 8'hFF, 16'd3, '0, '0));
    dir_rows.push_back(chk_row(ACT_GET, 8'h00, 16'd3, '0, '0, 1, ST_BAD_ADDR, 8'h00, 12'd0));
    dir_rows.push_back(chk_row(ACT_GET, 8'hFF, 16'd4000, '0, '0, 1, ST_NOT_ALLOC, 8'h00,
                               12'd0));
    dir_rows.push_back(chk_row(ACT_GET, 8'hFF, 16'hFFFF, '0, '0, 1, ST_BAD_ADDR, 8'h00,
                               12'd0));
    dir_rows.push_back(cfg_row(CFG_EPS, 13'd0));
    dir_rows.push_back(op_row(ACT_WRITE, 8'h00, 16'd0, 64'hA5A5_A5A5_5A5A_5A5A, '1));
    dir_rows.push_back(op_row(ACT_GET, 8'hFF, 16'd3, '0, '0));
    dir_rows.push_back(op_row(ACT_DELETE, 8'hFF, 16'd1, '0, '0));
    dir_rows.push_back(op_row(ACT_GET, 8'hFF, 16'd1, '0, '0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < dir_rows.size(); k++) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        write_reg(dir_rows[k].sel, dir_rows[k].val);
      end else begin
        send_item(dir_rows[k].it, n);
        if (dir_rows[k].typed) begin
          repeat (n) void'(slot_results_q.pop_back());
          if (dir_rows[k].n_typed != 0) slot_results_q.push_back(dir_rows[k].want);
        end
      end
    end

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_EPS, 13'd8);
          write_reg(CFG_FILE, CFG_W'($urandom_range(1, 254)));
          write_reg(CFG_LIMIT, 13'd4096);
        end
        1: begin
          // limit just above the used count so the store fills up
          write_reg(CFG_EPS, 13'd4);
          write_reg(CFG_FILE, 13'd0);
          write_reg(CFG_LIMIT, CFG_W'(used_cnt + 6));
        end
        2: begin
          write_reg(CFG_EPS, 13'd0);
          write_reg(CFG_FILE, 13'd255);
          write_reg(CFG_LIMIT, 13'd3);
        end
        default: begin
          write_reg(CFG_EPS, 13'd15);
          write_reg(CFG_FILE, CFG_W'($urandom_range(0, 255)));
          write_reg(CFG_LIMIT, CFG_W'($urandom_range(16, 4096)));
        end
      endcase
      quiet_tx = (phase == 1);
      quiet_rx = (phase == 1 || phase == 3);
      done = 0;
      while (done < PHASE_ITEMS) begin
        if ($urandom_range(0, 49) == 0) drain();
        it = rand_item();
        send_item(it, n);
        if (it.act != ACT_NOP) done++;
      end
    end

    drain();
    if (bad_cnt == 0 && slot_results_q.size() == 0)
      $display("slot_store_free_list_allocator_unit regression: pass");
    else
      $display("slot_store_free_list_allocator_unit regression: fail");
    $finish;
  end

endmodule
